### sv/cvs_pkg.sv
`default_nettype none

package cvs_pkg;

    localparam int VOLT_W            = 16;
    localparam int SUM_W             = 20;
    localparam int IDX_W             = 4;
    localparam int S_DATA_W          = 16;
    localparam int M_DATA_W          = 80;
    localparam int MAX_CELLS_DEFAULT = 16;

    localparam logic [VOLT_W-1:0] THRESHOLD_RESET = VOLT_W'(300);
    localparam logic [SUM_W-1:0]  SUM_SAT         = '1;

    // packed msb first, so pack_sum lands in the lowest bits
    typedef struct packed {
        logic              too_many_cells;
        logic              imbalance;
        logic [VOLT_W-1:0] spread;
        logic [IDX_W-1:0]  min_index;
        logic [VOLT_W-1:0] min_voltage;
        logic [IDX_W-1:0]  max_index;
        logic [VOLT_W-1:0] max_voltage;
        logic [SUM_W-1:0]  pack_sum;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

### sv/cell_voltage_statistics_top.sv
// Cell voltage statistics over one scan of battery cells.
// Input stream s_axis: one cell voltage per beat in s_axis_tdata, s_axis_tlast on the
// final cell of the scan. Result stream m_axis: one beat per scan, issued after the
// tlast beat, carrying pack sum, max and min with their first positions, spread,
// imbalance flag and too-many-cells flag.
// Configuration channel cfg_valid/cfg_ready/cfg_data writes the imbalance threshold;
// cfg_ready is always high and writes are meant only while the block is idle.
// The result is registered: a tlast beat passes the input and result registers.
// Throughput: one cell beat per cycle unless a tlast beat waits on a stalled result;
// running sum and compare on the input register load statistics and result registers.
// Cells past MAX_CELLS in a scan are dropped and only raise too_many_cells.
// Reset (aresetn low, synchronous) clears the running statistics, empties both stages
// and sets the threshold to 300 mV.
// When m_axis_tready is low a pending result holds; cell beats keep flowing until a
// second tlast beat reaches the input register, which then waits and backs up s_axis.
`default_nettype none

module cell_voltage_statistics_top #(
    parameter int MAX_CELLS = cvs_pkg::MAX_CELLS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [cvs_pkg::S_DATA_W-1:0]  s_axis_tdata,   // cell_voltage
    input  wire logic                          s_axis_tlast,   // last_cell
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // pack_sum, max_voltage, max_index, min_voltage, min_index, spread, imbalance,
    // too_many_cells, zero fill
    output logic [cvs_pkg::M_DATA_W-1:0]       m_axis_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cvs_pkg::VOLT_W-1:0]    cfg_data
);
    import cvs_pkg::*;

    localparam int CNT_W = $clog2(MAX_CELLS + 1);

    logic              in_valid_reg;
    logic [VOLT_W-1:0] in_volt_reg;
    logic              in_last_reg;

    logic [VOLT_W-1:0] thresh_reg;

    logic [SUM_W-1:0]  sum_reg,     sum_next,     sum_upd;
    logic [VOLT_W-1:0] max_reg,     max_next,     max_upd;
    logic [IDX_W-1:0]  max_pos_reg, max_pos_next, max_pos_upd;
    logic [VOLT_W-1:0] min_reg,     min_next,     min_upd;
    logic [IDX_W-1:0]  min_pos_reg, min_pos_next, min_pos_upd;
    logic [CNT_W-1:0]  count_reg,   count_next,   count_upd;
    logic              ovf_reg,     ovf_next,     ovf_upd;

    logic              out_valid_reg;
    result_t           out_reg;
    result_t           result;

    logic              fire;
    logic              take_cell;
    logic [SUM_W:0]    sum_add;
    logic [IDX_W-1:0]  pos;

    assign fire          = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_DATA_W'(out_reg);

    assign take_cell = count_reg < CNT_W'(MAX_CELLS);
    assign pos       = IDX_W'(count_reg);
    assign sum_add   = {1'b0, sum_reg} + (SUM_W + 1)'(in_volt_reg);

    always_comb begin
        sum_upd     = sum_reg;
        max_upd     = max_reg;
        max_pos_upd = max_pos_reg;
        min_upd     = min_reg;
        min_pos_upd = min_pos_reg;
        count_upd   = count_reg;
        ovf_upd     = ovf_reg;
        if (take_cell) begin
            if (count_reg == '0) begin
                sum_upd     = SUM_W'(in_volt_reg);
                max_upd     = in_volt_reg;
                min_upd     = in_volt_reg;
                max_pos_upd = '0;
                min_pos_upd = '0;
            end else begin
                sum_upd = sum_add[SUM_W] ? SUM_SAT : sum_add[SUM_W-1:0];
                if (in_volt_reg > max_reg) begin
                    max_upd     = in_volt_reg;
                    max_pos_upd = pos;
                end
                if (in_volt_reg < min_reg) begin
                    min_upd     = in_volt_reg;
                    min_pos_upd = pos;
                end
            end
            count_upd = count_reg + CNT_W'(1);
        end else begin
            ovf_upd = 1'b1;
        end
    end

    always_comb begin
        result.pack_sum       = sum_upd;
        result.max_voltage    = max_upd;
        result.max_index      = max_pos_upd;
        result.min_voltage    = min_upd;
        result.min_index      = min_pos_upd;
        result.spread         = max_upd - min_upd;
        result.imbalance      = result.spread > thresh_reg;
        result.too_many_cells = ovf_upd;
    end

    always_comb begin
        sum_next     = sum_reg;
        max_next     = max_reg;
        max_pos_next = max_pos_reg;
        min_next     = min_reg;
        min_pos_next = min_pos_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        if (fire) begin
            if (in_last_reg) begin
                sum_next     = '0;
                max_next     = '0;
                max_pos_next = '0;
                min_next     = '0;
                min_pos_next = '0;
                count_next   = '0;
                ovf_next     = 1'b0;
            end else begin
                sum_next     = sum_upd;
                max_next     = max_upd;
                max_pos_next = max_pos_upd;
                min_next     = min_upd;
                min_pos_next = min_pos_upd;
                count_next   = count_upd;
                ovf_next     = ovf_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            thresh_reg    <= THRESHOLD_RESET;
            sum_reg       <= '0;
            max_reg       <= '0;
            max_pos_reg   <= '0;
            min_reg       <= '0;
            min_pos_reg   <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                thresh_reg <= cfg_data;
            end
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (fire && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            sum_reg     <= sum_next;
            max_reg     <= max_next;
            max_pos_reg <= max_pos_next;
            min_reg     <= min_next;
            min_pos_reg <= min_pos_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_volt_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (fire && in_last_reg) begin
            out_reg <= result;
        end
    end

endmodule

`default_nettype wire

### sv/cvs_checker.sv
`default_nettype none

module cvs_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic [cvs_pkg::S_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                          s_axis_tlast,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [cvs_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [cvs_pkg::VOLT_W-1:0]    cfg_data
);
    import cvs_pkg::*;

    result_t res;

    assign res = result_t'(m_axis_tdata[RESULT_W-1:0]);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result beat right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> res.min_voltage <= res.max_voltage)
        else $error("min above max");

    a_spread: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> res.spread == VOLT_W'(res.max_voltage - res.min_voltage))
        else $error("spread does not match max minus min");

endmodule

bind cell_voltage_statistics_top cvs_checker u_cvs_checker (.*);

`default_nettype wire
